/* src/float_frame_tail_deframer_macros.svh */
// assertion helpers for the rtl datapath
// all checks are sampled on clk and held off while rst_n is low
`ifndef FLOAT_FRAME_TAIL_DEFRAMER_MACROS_SVH
`define FLOAT_FRAME_TAIL_DEFRAMER_MACROS_SVH

// same-cycle implication
`define FFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ffd_pkg.sv */
package ffd_pkg;

  localparam int MAX_WORDS_DEF = 64;
  localparam int WIDX_OUT_W    = 6;
  localparam int FLOAT_W       = 32;

  // tail sequence 00 00 80 7f, first three bytes as seen in the history register
  localparam logic [23:0] TAIL_HEAD = 24'h000080;
  localparam logic [7:0]  TAIL_LAST = 8'h7F;

  typedef struct packed {
    logic byte_take;  // input beat accepted this cycle
    logic issue_rd;   // read one stored byte
    logic load_out;   // move gathered word into the output register
  } cmd_t;

  typedef struct packed {
    logic tail_good;  // incoming byte closes a frame that must be emitted
    logic lane_end;   // read of the top byte of a word is being issued
    logic last_word;  // current word is the final one of the frame
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

/* src/ffd_ctrl.sv */
module ffd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffd_pkg::status_t sts,
  output ffd_pkg::cmd_t    cmd
);
  import ffd_pkg::*;

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_FETCH   = 2'd1;
  localparam logic [1:0] S_GATHER  = 2'd2;
  localparam logic [1:0] S_LOAD    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.byte_take = 1'b0;
    cmd.issue_rd  = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state_r)
      S_COLLECT: begin
        cmd.byte_take = in_valid;
        if (in_valid && sts.tail_good) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.issue_rd = 1'b1;
        if (sts.lane_end) begin
          state_nxt = S_GATHER;
        end
      end
      // last byte of the word lands in the gather register
      S_GATHER: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sts.last_word ? S_COLLECT : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_COLLECT);

endmodule

/* src/ffd_datapath.sv */
`include "float_frame_tail_deframer_macros.svh"

module ffd_datapath #(
  parameter int MAX_WORDS = ffd_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [7:0]                     in_byte_in,
  input  ffd_pkg::cmd_t                  cmd,
  output ffd_pkg::status_t               sts,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [ffd_pkg::FLOAT_W-1:0]    out_float_bits,
  output logic [ffd_pkg::WIDX_OUT_W-1:0] out_word_index,
  output logic                           out_last_of_frame
);
  import ffd_pkg::*;

  localparam int STORE_DEPTH = 4 * MAX_WORDS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 4);
  localparam int WIDX_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(STORE_DEPTH + 3);
  localparam logic [CNT_W-1:0] STORE_LIM = CNT_W'(STORE_DEPTH);

  // frame byte store, no reset
  logic [7:0] mem [STORE_DEPTH];

  logic [CNT_W-1:0]  cnt_r;
  logic [23:0]       recent_r;
  logic              ovf_r;
  logic [WIDX_W-1:0] last_widx_r;
  logic [WIDX_W-1:0] widx_r;
  logic [1:0]        lane_r;
  logic [7:0]        rd_data_r;
  logic              rd_pend_r;
  logic [31:0]       word_r;

  logic                  out_valid_r;
  logic [FLOAT_W-1:0]    out_bits_r;
  logic [WIDX_OUT_W-1:0] out_idx_r;
  logic                  out_last_r;

  logic              tail_hit;
  logic [CNT_W-1:0]  payload;
  logic [CNT_W-1:0]  words_m1;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_take;

  assign tail_hit = (cnt_r >= CNT_W'(3)) && (recent_r == TAIL_HEAD) && (in_byte_in == TAIL_LAST);
  assign payload  = cnt_r - CNT_W'(3);
  assign words_m1 = (payload >> 2) - CNT_W'(1);
  assign rd_addr  = ADDR_W'({widx_r, lane_r});
  assign out_take = out_valid_r && !out_stall;

  assign sts.tail_good = tail_hit && !ovf_r && (payload != '0) && (payload[1:0] == 2'b00)
                      && (payload <= STORE_LIM);
  assign sts.lane_end  = (lane_r == 2'd3);
  assign sts.last_word = (widx_r == last_widx_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // store write and registered store read
  always_ff @(posedge clk) begin
    if (cmd.byte_take && !tail_hit && (cnt_r < STORE_LIM)) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_byte_in;
    end
    if (cmd.issue_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      recent_r <= '0;
      ovf_r    <= 1'b0;
    end else if (cmd.byte_take) begin
      if (tail_hit) begin
        cnt_r    <= '0;
        recent_r <= '0;
        ovf_r    <= 1'b0;
      end else begin
        if (cnt_r >= CNT_CAP) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        recent_r <= {recent_r[15:0], in_byte_in};
      end
    end
  end

  // drain sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r    <= '0;
      lane_r    <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.issue_rd;
      if (cmd.byte_take && sts.tail_good) begin
        widx_r <= '0;
        lane_r <= '0;
      end else begin
        if (cmd.issue_rd) begin
          lane_r <= lane_r + 2'd1;
        end
        if (cmd.load_out && !sts.last_word) begin
          widx_r <= widx_r + WIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_take && sts.tail_good) begin
      last_widx_r <= words_m1[WIDX_W-1:0];
    end
    // little endian: first byte shifts down to bits 7..0
    if (rd_pend_r) begin
      word_r <= {rd_data_r, word_r[31:8]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bits_r <= word_r;
      out_idx_r  <= WIDX_OUT_W'(widx_r);
      out_last_r <= sts.last_word;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_float_bits    = out_bits_r;
  assign out_word_index    = out_idx_r;
  assign out_last_of_frame = out_last_r;

  `FFD_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid_r || !out_stall, "load over held word")
  `FFD_ASSERT_NOW(a_no_take_in_drain, cmd.issue_rd, !cmd.byte_take, "byte taken while draining")
  `FFD_ASSERT_NOW(a_widx_bound, cmd.issue_rd, widx_r <= last_widx_r, "read past frame end")
  `FFD_ASSERT_NEXT(a_frame_restart, cmd.byte_take && tail_hit, (cnt_r == '0) && !ovf_r, "frame not restarted")

endmodule

/* src/float_frame_tail_deframer.sv */
// after the tail's 7f beat each word goes through S_FETCH, S_GATHER and S_LOAD
// 1 byte per cycle while collecting; while draining, words are paced by the single
//   byte read port of the frame store (4 reads, gather, load) and by out_stall
// input is stalled from the tail beat until the last word enters the output register
// reset: synchronous active-low rst_n clears the controller, counters and output valid;
//   frame store contents are not reset
module float_frame_tail_deframer #(
  parameter int MAX_WORDS = ffd_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte_in,
  // word result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ffd_pkg::FLOAT_W-1:0]    out_float_bits,
  output logic [ffd_pkg::WIDX_OUT_W-1:0] out_word_index,
  output logic                           out_last_of_frame
);
  import ffd_pkg::*;

  // commands from the controller, status back from the datapath
  cmd_t    cmd;
  status_t sts;

  // controller: collects beats, then sequences reads and loads per word
  ffd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: frame store, tail detect, word gather, output register
  ffd_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte_in        (in_byte_in),
    .cmd               (cmd),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_float_bits    (out_float_bits),
    .out_word_index    (out_word_index),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

/* tb/ffd_word_checker.sv */
`timescale 1ns / 100ps

module ffd_word_checker #(
  parameter int MAX_WORDS = ffd_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_byte_in,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ffd_pkg::FLOAT_W-1:0]    out_float_bits,
  input  logic [ffd_pkg::WIDX_OUT_W-1:0] out_word_index,
  input  logic                           out_last_of_frame,
  output int                             fail_count,
  output int                             words_pending
);

  localparam int PAYLOAD_CAP = 4 * MAX_WORDS;
  localparam int COUNT_CAP   = PAYLOAD_CAP + 3;

  typedef struct packed {
    logic [ffd_pkg::FLOAT_W-1:0]    bits;
    logic [ffd_pkg::WIDX_OUT_W-1:0] index;
    logic                           last;
  } frame_word_t;

  logic [7:0]  frame_bytes [0:255];
  logic [8:0]  frame_len;
  logic [23:0] history;
  logic        overgrown;
  frame_word_t expected_words [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string what);
    $display("ffd check %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic start_frame();
    frame_len = '0;
    history   = '0;
    overgrown = 1'b0;
  endtask

  // one accepted byte beat; a completed tail releases the frame's words
  task automatic absorb_byte(input logic [7:0] b);
    int          payload;
    frame_word_t w;
    if (frame_len >= 3 && history == ffd_pkg::TAIL_HEAD && b == ffd_pkg::TAIL_LAST) begin
      payload = int'(frame_len) - 3;
      if (!overgrown && payload != 0 && payload % 4 == 0 && payload <= PAYLOAD_CAP) begin
        for (int k = 0; k < payload / 4; k++) begin
          w.bits  = {frame_bytes[4*k+3], frame_bytes[4*k+2],
                     frame_bytes[4*k+1], frame_bytes[4*k]};
          w.index = ffd_pkg::WIDX_OUT_W'(k);
          w.last  = (k == payload / 4 - 1);
          expected_words.push_back(w);
        end
      end
      start_frame();
    end else begin
      if (frame_len >= COUNT_CAP) begin
        overgrown = 1'b1;
      end else begin
        if (frame_len < PAYLOAD_CAP) frame_bytes[frame_len] = b;
        frame_len++;
      end
      history = {history[15:0], b};
    end
  endtask

  always @(posedge clk) begin
    frame_word_t want;
    if (!rst_n) begin
      start_frame();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h idx %0d", out_float_bits,
                                    out_word_index));
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (out_float_bits !== want.bits)
            report_mismatch($sformatf("float_bits %h, want %h (idx %0d)", out_float_bits,
                                      want.bits, want.index));
          if (out_word_index !== want.index)
            report_mismatch($sformatf("word_index %0d, want %0d", out_word_index,
                                      want.index));
          if (out_last_of_frame !== want.last)
            report_mismatch($sformatf("last_of_frame %b, want %b (idx %0d)",
                                      out_last_of_frame, want.last, want.index));
        end
      end
      if (in_valid && !in_stall) absorb_byte(in_byte_in);
    end
    words_pending <= expected_words.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ffd_pkg::*;

  localparam int MAX_WORDS    = MAX_WORDS_DEF;
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int RANDOM_BYTES = 400;
  localparam int DRAIN_CYCLES = 24;      // idle cycles after the last expected word is checked
  localparam int IDLE_PCT     = 13;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte_in  = 8'h00;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [FLOAT_W-1:0]    out_float_bits;
  logic [WIDX_OUT_W-1:0] out_word_index;
  logic                  out_last_of_frame;

  // calm stretch: no gaps on the byte side, no stalls on the word side
  bit calm        = 1'b0;
  int bytes_sent  = 0;
  int cycle_count = 0;
  int fail_count;
  int words_pending;

  float_frame_tail_deframer #(.MAX_WORDS(MAX_WORDS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_float_bits    (out_float_bits),
    .out_word_index    (out_word_index),
    .out_last_of_frame (out_last_of_frame)
  );

  ffd_word_checker #(.MAX_WORDS(MAX_WORDS)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_float_bits    (out_float_bits),
    .out_word_index    (out_word_index),
    .out_last_of_frame (out_last_of_frame),
    .fail_count        (fail_count),
    .words_pending     (words_pending)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // word side back-pressure, independent of anything the block does
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("float_frame_tail_deframer: mismatch");
      $finish;
    end
  end

  // one byte beat: optional idle cycles first, then hold valid until it is taken
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // count bytes, all equal to fixed_value, or random when fixed_value is negative
  task automatic send_fill(input int count, input int fixed_value);
    for (int i = 0; i < count; i++)
      send_byte(fixed_value < 0 ? 8'($urandom_range(0, 255)) : 8'(fixed_value));
  endtask

  // the 00 00 80 7f frame delimiter
  task automatic send_tail();
    send_byte(TAIL_HEAD[23:16]);
    send_byte(TAIL_HEAD[15:8]);
    send_byte(TAIL_HEAD[7:0]);
    send_byte(TAIL_LAST);
  endtask

  initial begin
    int random_start;
    int calm_from;
    int pick;
    int n_words;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    // all-ones and all-zeros single word frames
    send_fill(4, 8'hFF);
    send_tail();
    send_fill(4, 8'h00);
    send_tail();
    // frame holding only the tail, dropped
    send_tail();
    // 00 80 7f right after a frame ends: too few frame bytes before 7f, so no tail;
    // those three bytes plus one more become a valid one word payload
    send_byte(TAIL_HEAD[15:8]);
    send_byte(TAIL_HEAD[7:0]);
    send_byte(TAIL_LAST);
    send_fill(1, -1);
    send_tail();
    // lengths that are not a multiple of four, dropped
    send_fill(5, -1);
    send_tail();
    send_fill(3, -1);
    send_tail();
    // largest frame that fits: every word index up to the top
    send_fill(4 * MAX_WORDS, -1);
    send_tail();
    // one byte too many, then far past the store: both dropped, tail still found
    send_fill(4 * MAX_WORDS + 1, -1);
    send_tail();
    send_fill(4 * MAX_WORDS + 44, -1);
    send_tail();
    // normal frame right after an overflow
    send_fill(8, -1);
    send_tail();

    // random part: mostly well-formed frames, some broken ones and noise
    random_start = bytes_sent;
    calm_from    = random_start + $urandom_range(60, 160);
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      calm = (bytes_sent >= calm_from) && (bytes_sent < calm_from + 150);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // good frame, small sizes mostly, now and then a long one
        n_words = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAX_WORDS)
                                               : $urandom_range(1, 8);
        send_fill(4 * n_words, -1);
        send_tail();
      end else if (pick < 88) begin
        // tail after a random length, usually a bad one
        send_fill($urandom_range(0, 14), -1);
        send_tail();
      end else if (pick < 95) begin
        // loose bytes that run into the next frame
        send_fill($urandom_range(1, 10), -1);
      end else begin
        // broken tail: head of the delimiter and a random closing byte
        send_byte(TAIL_HEAD[23:16]);
        send_byte(TAIL_HEAD[15:8]);
        send_byte(TAIL_HEAD[7:0]);
        send_fill(1, -1);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // let the checker's count take in the last beat, then drain
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("float_frame_tail_deframer: match");
    end else begin
      $display("float_frame_tail_deframer: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/ffd_pkg.sv
src/ffd_ctrl.sv
src/ffd_datapath.sv
src/float_frame_tail_deframer.sv
tb/ffd_word_checker.sv
tb/tb_top.sv
